>>> hdl/eevdf_pkg.sv
// ----------------------------------------------------------------------------
// eevdf_pkg
// Shared types and constants of the EEVDF run queue selector.
// ----------------------------------------------------------------------------
package eevdf_pkg;

    // table and fixed-point set-up
    localparam int NUM_SLOTS = 32;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int FRAC_BITS = 16;
    localparam int EPSILON   = 1;

    // field widths
    localparam int TIME_W   = 64;
    localparam int UPTIME_W = 63;
    localparam int CLIENT_W = 5;
    localparam int PRIO_W   = 6;
    localparam int WEIGHT_W = 11;
    localparam int WSUM_W   = 16;
    localparam int SLICE_W  = 32;
    localparam int CFG_W    = 32;

    // divider iteration counter width
    localparam int DIV_CNT_W = $clog2(TIME_W + FRAC_BITS + 1);

    typedef enum logic [1:0] {
        OP_ENTER = 2'd0,
        OP_LEAVE = 2'd1,
        OP_SCHED = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OCCUPIED = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    typedef enum logic {
        CFG_TIME_SLICE  = 1'b0,
        CFG_WEIGHT_BASE = 1'b1
    } t_cfg_idx;

    // request to the shared divider
    typedef struct packed {
        logic              start;
        logic              frac;
        logic [TIME_W-1:0] dividend;
        logic [WSUM_W-1:0] divisor;
    } t_div_req;

    // divider response
    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] quot;
    } t_div_rsp;

endpackage

>>> hdl/eevdf_runqueue_selector.sv
// ----------------------------------------------------------------------------
// eevdf_runqueue_selector
// Single-CPU EEVDF run queue over a table of client slots.
// ----------------------------------------------------------------------------
// One item at a time: o_in_ready is high only when the sequencer is idle.
// All divisions run through a single shared divider that retires one
// quotient bit per cycle. While a client runs, each operation but a no-op
// first spends three fixed-point divisions on virtual time and on the
// running client's eligible time and deadline; when the block is idle or
// empty these are skipped. Then an enter on a free slot runs one more
// division for the new deadline, a leave of a queued client a lag product
// and, unless the table is then empty, the correction division, and a
// schedule a scan of the slot table; a no-op goes straight to the result.
// A finished result waits in the output register, so the next item may be
// taken before it is read.
// ----------------------------------------------------------------------------
module eevdf_runqueue_selector (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [eevdf_pkg::CFG_W-1:0]    i_cfg_wdata,
    // input items
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_operation,
    input  logic [eevdf_pkg::CLIENT_W-1:0] i_client_slot,
    input  logic [eevdf_pkg::PRIO_W-1:0]   i_priority_req,
    input  logic [eevdf_pkg::UPTIME_W-1:0] i_uptime,
    // result items
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [eevdf_pkg::CLIENT_W-1:0] o_running_slot,
    output logic                           o_idle,
    output logic [eevdf_pkg::WSUM_W-1:0]   o_total_weight,
    output logic [1:0]                     o_status
);
    import eevdf_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_VT_DIV   = 12'b0000_0000_0010,
        S_CUR_DIV1 = 12'b0000_0000_0100,
        S_CUR_DIV2 = 12'b0000_0000_1000,
        S_OP_RD    = 12'b0000_0001_0000,
        S_OP       = 12'b0000_0010_0000,
        S_ENT_DIV  = 12'b0000_0100_0000,
        S_LV_MUL   = 12'b0000_1000_0000,
        S_LV_DIV   = 12'b0001_0000_0000,
        S_SCAN     = 12'b0010_0000_0000,
        S_DONE     = 12'b0100_0000_0000,
        S_SPARE    = 12'b1000_0000_0000
    } t_state;

    t_state                r_state;
    logic [SLICE_W-1:0]    r_time_slice;
    logic [WEIGHT_W-1:0]   r_weight_base;
    logic [NUM_SLOTS-1:0]  r_valid;
    logic [TIME_W-1:0]     r_vt;
    logic [TIME_W-1:0]     r_last;
    logic [WSUM_W-1:0]     r_ws;
    logic [SLOT_W-1:0]     r_cur;
    logic                  r_idle;
    t_op                   r_op;
    logic [CLIENT_W-1:0]   r_slot;
    logic [PRIO_W-1:0]     r_prio;
    logic [TIME_W-1:0]     r_delta;
    logic [TIME_W-1:0]     r_tmp;
    logic [TIME_W-1:0]     r_lag;
    logic [WEIGHT_W-1:0]   r_w;
    t_status               r_status;
    logic                  r_div_go;
    logic [SLOT_W-1:0]     r_addr;
    logic [SLOT_W-1:0]     r_pidx;
    logic                  r_pvld;
    logic                  r_adone;
    logic                  r_found;
    logic [SLOT_W-1:0]     r_best;
    logic [TIME_W-1:0]     r_best_dl;
    logic                  r_o_valid;
    logic [CLIENT_W-1:0]   r_o_slot;
    logic                  r_o_idle;
    logic [WSUM_W-1:0]     r_o_ws;
    t_status               r_o_status;

    t_div_req              div_req;
    t_div_rsp              div_rsp;
    logic                  div_state;
    logic                  div_done;
    logic [TIME_W-1:0]     lag_mag;
    logic                  lag_neg;
    logic [WEIGHT_W-1:0]   rd_w;
    logic [TIME_W-1:0]     rd_elig;
    logic [TIME_W-1:0]     rd_dl;
    logic                  w_we;
    logic                  t_we;
    logic [TIME_W-1:0]     elig_wdata;
    logic [TIME_W-1:0]     dl_wdata;
    logic [SLOT_W-1:0]     slot_idx;
    logic                  slot_ok;
    logic [WEIGHT_W:0]     w_raw;
    logic [WEIGHT_W-1:0]   w_new;
    logic [WSUM_W:0]       ws_add;
    logic [WSUM_W-1:0]     ws_sub;
    logic [TIME_W-1:0]     elig_diff;
    logic signed [TIME_W-1:0] elig_sh;
    logic                  cand_take;
    logic                  scan_last;
    logic                  accept;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // slot decode and new weight
    assign slot_idx = SLOT_W'(r_slot);
    assign slot_ok  = (32'(r_slot) < NUM_SLOTS);
    assign w_raw    = {1'b0, r_weight_base} + (WEIGHT_W + 1)'(r_prio);
    always_comb begin
        if (w_raw[WEIGHT_W]) begin
            w_new = '1;
        end else if (w_raw == '0) begin
            w_new = WEIGHT_W'(1);
        end else begin
            w_new = w_raw[WEIGHT_W-1:0];
        end
    end
    assign ws_add = (WSUM_W + 1)'(r_ws) + (WSUM_W + 1)'(w_new);
    assign ws_sub = (r_ws > WSUM_W'(rd_w)) ? r_ws - WSUM_W'(rd_w) : '0;

    // signed lag magnitude for the leave correction
    assign lag_neg = r_lag[TIME_W-1];
    assign lag_mag = lag_neg ? (TIME_W'(0) - r_lag) : r_lag;

    // divider request
    assign div_state = (r_state == S_VT_DIV) || (r_state == S_CUR_DIV1) ||
                       (r_state == S_CUR_DIV2) || (r_state == S_ENT_DIV) ||
                       (r_state == S_LV_DIV);
    assign div_done  = div_state && r_div_go && div_rsp.done;
    always_comb begin
        div_req.start    = div_state && !r_div_go;
        div_req.frac     = 1'b1;
        div_req.dividend = r_delta;
        div_req.divisor  = r_ws;
        case (r_state)
            S_CUR_DIV1: begin
                div_req.divisor = WSUM_W'(rd_w);
            end
            S_CUR_DIV2: begin
                div_req.dividend = TIME_W'(r_time_slice);
                div_req.divisor  = WSUM_W'(rd_w);
            end
            S_ENT_DIV: begin
                div_req.dividend = TIME_W'(r_time_slice);
                div_req.divisor  = WSUM_W'(r_w);
            end
            S_LV_DIV: begin
                div_req.frac     = 1'b0;
                div_req.dividend = lag_mag;
            end
            default: begin
                div_req.frac = 1'b1;
            end
        endcase
    end

    eevdf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // slot stores
    assign w_we       = (r_state == S_ENT_DIV) && div_done;
    assign t_we       = ((r_state == S_CUR_DIV2) || (r_state == S_ENT_DIV)) && div_done;
    assign elig_wdata = (r_state == S_ENT_DIV) ? r_vt : r_tmp;
    assign dl_wdata   = elig_wdata + div_rsp.quot;

    eevdf_ram #(.WIDTH(WEIGHT_W), .DEPTH(NUM_SLOTS)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (r_addr),
        .i_wdata (r_w),
        .o_rdata (rd_w)
    );

    eevdf_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_elig_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_addr  (r_addr),
        .i_wdata (elig_wdata),
        .o_rdata (rd_elig)
    );

    eevdf_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_dl_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_addr  (r_addr),
        .i_wdata (dl_wdata),
        .o_rdata (rd_dl)
    );

    // scan compare on the slot read last cycle
    assign elig_diff = rd_elig - r_vt;
    assign elig_sh   = $signed(elig_diff) >>> FRAC_BITS;
    assign cand_take = r_pvld && r_valid[r_pidx] &&
                       (elig_sh <= $signed(TIME_W'(EPSILON))) &&
                       (!r_found || ($signed(rd_dl) < $signed(r_best_dl)));
    assign scan_last = r_pvld && (r_pidx == SLOT_W'(NUM_SLOTS - 1));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_slice  <= SLICE_W'(10000000);
            r_weight_base <= WEIGHT_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_TIME_SLICE) begin
                r_time_slice <= i_cfg_wdata[SLICE_W-1:0];
            end else begin
                r_weight_base <= i_cfg_wdata[WEIGHT_W-1:0];
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_vt      <= '0;
            r_last    <= '0;
            r_ws      <= '0;
            r_cur     <= '0;
            r_idle    <= 1'b1;
            r_div_go  <= 1'b0;
            r_o_valid <= 1'b0;
            r_pvld    <= 1'b0;
            r_adone   <= 1'b0;
            r_found   <= 1'b0;
            r_status  <= ST_OK;
        end else begin
            if (div_req.start) begin
                r_div_go <= 1'b1;
            end
            if (div_done) begin
                r_div_go <= 1'b0;
            end
            if (r_o_valid && i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op     <= t_op'(i_operation);
                        r_slot   <= i_client_slot;
                        r_prio   <= i_priority_req;
                        r_status <= ST_OK;
                        r_delta  <= {1'b0, i_uptime} - r_last;
                        r_addr   <= r_cur;
                        if (t_op'(i_operation) == OP_NOP) begin
                            r_state <= S_DONE;
                        end else begin
                            r_last <= {1'b0, i_uptime};
                            if ((r_ws == '0) || r_idle) begin
                                r_vt    <= '0;
                                r_addr  <= SLOT_W'(i_client_slot);
                                r_state <= S_OP_RD;
                            end else begin
                                r_state <= S_VT_DIV;
                            end
                        end
                    end
                end
                S_VT_DIV: begin
                    if (div_done) begin
                        r_vt <= r_vt + div_rsp.quot;
                        if (r_valid[r_cur]) begin
                            r_state <= S_CUR_DIV1;
                        end else begin
                            r_addr  <= slot_idx;
                            r_state <= S_OP_RD;
                        end
                    end
                end
                S_CUR_DIV1: begin
                    if (div_done) begin
                        r_tmp   <= rd_elig + div_rsp.quot;
                        r_state <= S_CUR_DIV2;
                    end
                end
                S_CUR_DIV2: begin
                    if (div_done) begin
                        r_addr  <= slot_idx;
                        r_state <= S_OP_RD;
                    end
                end
                S_OP_RD: begin
                    r_state <= S_OP;
                end
                S_OP: begin
                    case (r_op)
                        OP_ENTER: begin
                            if (!slot_ok || r_valid[slot_idx]) begin
                                r_status <= ST_OCCUPIED;
                                r_state  <= S_DONE;
                            end else begin
                                r_valid[slot_idx] <= 1'b1;
                                r_w     <= w_new;
                                r_ws    <= ws_add[WSUM_W] ? '1 : ws_add[WSUM_W-1:0];
                                r_state <= S_ENT_DIV;
                            end
                        end
                        OP_LEAVE: begin
                            if (!slot_ok || !r_valid[slot_idx]) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_DONE;
                            end else begin
                                r_valid[slot_idx] <= 1'b0;
                                r_w   <= rd_w;
                                r_tmp <= r_vt - rd_elig;
                                r_ws  <= ws_sub;
                                if (!r_idle && (r_cur == slot_idx)) begin
                                    r_idle <= 1'b1;
                                    r_cur  <= '0;
                                end
                                r_state <= S_LV_MUL;
                            end
                        end
                        OP_SCHED: begin
                            r_addr  <= '0;
                            r_pvld  <= 1'b0;
                            r_adone <= 1'b0;
                            r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_ENT_DIV: begin
                    if (div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_LV_MUL: begin
                    r_lag <= r_tmp * TIME_W'(r_w);
                    if (r_ws == '0) begin
                        r_vt    <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_LV_DIV;
                    end
                end
                S_LV_DIV: begin
                    if (div_done) begin
                        r_vt <= lag_neg ? (r_vt - div_rsp.quot) : (r_vt + div_rsp.quot);
                        r_state <= S_DONE;
                    end
                end
                S_SCAN: begin
                    // address runs one slot ahead of the compare
                    if (!r_adone) begin
                        r_addr <= r_addr + SLOT_W'(1);
                        if (r_addr == SLOT_W'(NUM_SLOTS - 1)) begin
                            r_adone <= 1'b1;
                        end
                    end
                    r_pidx <= r_addr;
                    r_pvld <= 1'b1;
                    if (cand_take) begin
                        r_found   <= 1'b1;
                        r_best    <= r_pidx;
                        r_best_dl <= rd_dl;
                    end
                    if (scan_last) begin
                        r_pvld <= 1'b0;
                        if (cand_take || r_found) begin
                            r_idle <= 1'b0;
                            r_cur  <= cand_take ? r_pidx : r_best;
                        end else begin
                            r_idle <= 1'b1;
                            r_cur  <= '0;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_o_valid || i_out_ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_slot   <= r_idle ? '0 : CLIENT_W'(r_cur);
                        r_o_idle   <= r_idle;
                        r_o_ws     <= r_ws;
                        r_o_status <= r_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_running_slot = r_o_slot;
    assign o_idle         = r_o_idle;
    assign o_total_weight = r_o_ws;
    assign o_status       = r_o_status;

    // idle always parks the running slot at zero
    a_idle_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idle |-> (r_cur == '0))
        else $error("idle with nonzero running slot");

    // between items a running client occupies a valid slot
    a_cur_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && !r_idle) |-> r_valid[r_cur])
        else $error("running client not queued");

    // scan winner is always a queued slot
    a_best_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && r_found) |-> r_valid[r_best])
        else $error("scan picked an empty slot");

    // divider is only started once per divide state
    a_div_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> !div_req.start)
        else $error("divider restarted back to back");

endmodule

>>> hdl/eevdf_ram.sv
// ----------------------------------------------------------------------------
// eevdf_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module eevdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/eevdf_div.sv
// ----------------------------------------------------------------------------
// eevdf_div
// Radix-2 restoring divider, one quotient bit per cycle. With frac set the
// dividend is extended by FRAC_BITS zero bits, giving (x << FRAC_BITS) / w.
// ----------------------------------------------------------------------------
module eevdf_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  eevdf_pkg::t_div_req i_req,
    output eevdf_pkg::t_div_rsp o_rsp
);
    import eevdf_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [TIME_W-1:0]    r_num, n_num;
    logic [TIME_W-1:0]    r_quot, n_quot;
    logic [WSUM_W-1:0]    r_den, n_den;
    logic [WSUM_W-1:0]    r_rem, n_rem;
    logic [WSUM_W:0]      rem_sh;
    logic [WSUM_W:0]      rem_sub;

    // one shift-subtract step
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_num   = r_num;
        n_quot  = r_quot;
        n_den   = r_den;
        n_rem   = r_rem;
        rem_sh  = {r_rem, r_num[TIME_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_num  = i_req.dividend;
            n_den  = (i_req.divisor == '0) ? WSUM_W'(1) : i_req.divisor;
            n_rem  = '0;
            n_quot = '0;
            n_cnt  = i_req.frac ? DIV_CNT_W'(TIME_W + FRAC_BITS) : DIV_CNT_W'(TIME_W);
        end else if (r_busy) begin
            n_num = {r_num[TIME_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, r_den}) begin
                n_rem  = rem_sub[WSUM_W-1:0];
                n_quot = {r_quot[TIME_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh[WSUM_W-1:0];
                n_quot = {r_quot[TIME_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num  <= n_num;
        r_quot <= n_quot;
        r_den  <= n_den;
        r_rem  <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule
